// ===== hdl/ioh_pkg.sv =====
package ioh_pkg;

	localparam int MaxBins = 16;
	localparam int MaxWidth = 1024;
	localparam int BinW = $clog2(MaxBins);
	localparam int BinCntW = BinW + 1;
	localparam int ColW = $clog2(MaxWidth);
	localparam int AddrW = ColW + BinW;
	localparam int CordicSteps = 14;
	localparam int RowSumW = 40;
	localparam int BinSumW = 48;
	localparam int MagW = 20;
	localparam int RadW = 39;
	localparam int CorW = 24;

	localparam logic [RowSumW-1:0] RowSumMax = {RowSumW{1'b1}};
	localparam logic [BinSumW-1:0] BinSumMax = {BinSumW{1'b1}};

	localparam logic [1:0] REG_BIN_COUNT = 2'd0;
	localparam logic [1:0] REG_FULL_ORIENT = 2'd1;

	// atan(2^-i) in 2^-16 turn units
	function automatic logic [15:0] angle_step(input logic [3:0] i);
		logic [15:0] r;
		case (i)
			4'd0: r = 16'd8192;
			4'd1: r = 16'd4836;
			4'd2: r = 16'd2555;
			4'd3: r = 16'd1297;
			4'd4: r = 16'd651;
			4'd5: r = 16'd326;
			4'd6: r = 16'd163;
			4'd7: r = 16'd81;
			4'd8: r = 16'd41;
			4'd9: r = 16'd20;
			4'd10: r = 16'd10;
			4'd11: r = 16'd5;
			4'd12: r = 16'd3;
			4'd13: r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic [MagW-1:0] mag;
		logic [15:0] angle;
	} ioh_polar_t;

endpackage

// ===== hdl/ioh_polar.sv =====
// magnitude by bit-pair square root and angle by cordic, both one step a cycle
module ioh_polar (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [10:0] gx,
	input logic signed [10:0] gy,
	output logic done,
	output ioh_pkg::ioh_polar_t res
);
	import ioh_pkg::*;

	logic busy_q;
	logic [4:0] step_q;
	logic [RadW-1:0] rem_q;
	logic [MagW-1:0] root_q;
	logic signed [CorW-1:0] x_q, y_q;
	logic [15:0] z_q;
	logic zero_q;
	logic [21:0] sq;
	logic signed [CorW-1:0] xs, ys;
	logic [RadW-1:0] trial, rem_sh;
	logic [3:0] ci;

	// squared radius (fits 22 bits)
	assign sq = (22'(gx) * 22'(gx)) + (22'(gy) * 22'(gy));
	assign ci = step_q[3:0];
	assign xs = x_q >>> ci;
	assign ys = y_q >>> ci;
	// restoring root: bring down two bits of radicand per step
	assign rem_sh = rem_q;
	assign trial = RadW'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == 5'(MagW - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				step_q <= step_q + 5'd1;
			end
		end
	end

	// datapath: radicand is sq<<16 (38 bits, padded to 40 = 20 bit pairs)
	logic [39:0] rad_q;
	logic [RadW:0] cur;
	assign cur = {rem_sh[RadW-2:0], rad_q[39:38]};
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rad_q <= {sq, 16'd0, 2'b00} >> 2;
			rem_q <= '0;
			root_q <= '0;
			zero_q <= (gx == 11'sd0) && (gy == 11'sd0);
			if (gx < 0) begin
				x_q <= -(CorW'(gx) <<< 8);
				y_q <= -(CorW'(gy) <<< 8);
				z_q <= 16'd32768;
			end else begin
				x_q <= CorW'(gx) <<< 8;
				y_q <= CorW'(gy) <<< 8;
				z_q <= 16'd0;
			end
		end else if (busy_q) begin
			rad_q <= {rad_q[37:0], 2'b00};
			if (cur >= {1'b0, trial}) begin
				rem_q <= cur[RadW-1:0] - trial;
				root_q <= {root_q[MagW-2:0], 1'b1};
			end else begin
				rem_q <= cur[RadW-1:0];
				root_q <= {root_q[MagW-2:0], 1'b0};
			end
			// cordic micro-rotation
			if (step_q < 5'(CordicSteps)) begin
				if (y_q > 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + angle_step(ci);
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - angle_step(ci);
				end
			end
		end
	end

	assign res.mag = root_q;
	assign res.angle = zero_q ? 16'd0 : z_q;
endmodule

// ===== hdl/integral_orientation_histogram.sv =====
// integral orientation histogram, one pixel gradient per input item
// input channel: grad_x, grad_y, row_end, frame_end under valid/ready,
// pixels in raster order
// output channel: one item per bin in use (bin_index, bin_sum, pixel_done),
// bins ascending, pixel_done on the last
// config: apb writes, register 0 bin_count at 0x0, 1 full_orientation at 0x4
// path: 20 square-root steps (cordic runs alongside), a hand-over of the
// done flag, the multiply, the split, 2 row-sum updates, a line-store
// read and the output register load lead to the first output item
// per bin: a line-store read, an output load and the handshake; the
// polar unit and the single line-store port bound how often pixels are taken
// ready is low while a pixel is in work; a stalled receiver holds the
// sequencer, the current bin waits in the output register
// reset: row sums cleared, column zero, first row flag set, bin_count 8,
// half orientation; the line store is not cleared, and its read value is
// taken as zero while the first row flag is set
module integral_orientation_histogram (
	input logic clk,
	input logic arst_n,
	input logic valid,
	output logic ready,
	input logic signed [10:0] grad_x,
	input logic signed [10:0] grad_y,
	input logic row_end,
	input logic frame_end,
	output logic out_valid,
	input logic out_ready,
	output logic [3:0] bin_index,
	output logic [47:0] bin_sum,
	output logic pixel_done,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ioh_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_POLAR = 3'd1;
	localparam logic [2:0] ST_MUL = 3'd2;
	localparam logic [2:0] ST_SPLIT = 3'd3;
	localparam logic [2:0] ST_ADD = 3'd4;
	localparam logic [2:0] ST_READ = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;

	logic [2:0] state_q;
	logic [BinCntW-1:0] bin_count_q;
	logic full_q;
	logic [ColW-1:0] col_q;
	logic first_q;
	logic [RowSumW-1:0] rows_q [MaxBins];
	logic [BinSumW-1:0] line_mem [MaxWidth*MaxBins];
	logic [BinSumW-1:0] above_q;
	logic rend_q, fend_q;
	logic polar_start, polar_done;
	ioh_polar_t polar;
	logic [BinCntW-1:0] bins_used;
	logic [BinW-1:0] n_q, lo_q, hi_q;
	logic [20:0] p_q;
	logic [15:0] ang;
	logic [MagW-1:0] mag_q;
	logic [MagW+15:0] prod_q;
	logic [MagW-1:0] up_q;
	logic add_hi_q;
	logic [RowSumW:0] rsum;
	logic [BinSumW:0] osum;
	logic [AddrW-1:0] addr;
	logic wr_cfg;

	// effective bin count
	always_comb begin
		if (bin_count_q == '0) bins_used = BinCntW'(1);
		else if (bin_count_q > BinCntW'(MaxBins)) bins_used = BinCntW'(MaxBins);
		else bins_used = bin_count_q;
	end

	// config port
	assign pready = 1'b1;
	assign wr_cfg = psel && penable && pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= BinCntW'(8);
			full_q <= 1'b0;
		end else if (wr_cfg) begin
			case (paddr[2:2])
				REG_BIN_COUNT[0]: bin_count_q <= pwdata[BinCntW-1:0];
				REG_FULL_ORIENT[0]: full_q <= pwdata[0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr[2:2])
			REG_BIN_COUNT[0]: prdata = 32'(bin_count_q);
			REG_FULL_ORIENT[0]: prdata = 32'(full_q);
			default: prdata = '0;
		endcase
	end

	assign ready = (state_q == ST_IDLE);
	assign polar_start = valid && ready;

	ioh_polar u_polar (
		.clk(clk), .arst_n(arst_n), .start(polar_start),
		.gx(grad_x), .gy(grad_y), .done(polar_done), .res(polar)
	);

	// fold angle into span
	assign ang = (!full_q && polar.angle[15]) ? {1'b0, polar.angle[14:0]} : polar.angle;
	assign addr = {col_q, n_q};
	assign rsum = {1'b0, rows_q[add_hi_q ? hi_q : lo_q]}
		+ (RowSumW+1)'(add_hi_q ? up_q : mag_q - up_q);
	assign osum = {1'b0, rows_q[n_q]} + {1'b0, first_q ? BinSumW'(0) : above_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			col_q <= '0;
			first_q <= 1'b1;
			for (int i = 0; i < MaxBins; i++) rows_q[i] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (polar_start) state_q <= ST_POLAR;
				ST_POLAR: if (polar_done) state_q <= ST_MUL;
				ST_MUL: state_q <= ST_SPLIT;
				ST_SPLIT: state_q <= ST_ADD;
				ST_ADD: begin
					if (add_hi_q) state_q <= ST_READ;
					rows_q[add_hi_q ? hi_q : lo_q] <= rsum[RowSumW] ? RowSumMax
						: rsum[RowSumW-1:0];
				end
				ST_READ: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
					end else if (out_ready) begin
						out_valid <= 1'b0;
						if (pixel_done) begin
							state_q <= ST_IDLE;
							if (rend_q || fend_q) begin
								for (int i = 0; i < MaxBins; i++) rows_q[i] <= '0;
								col_q <= '0;
								first_q <= fend_q;
							end else begin
								col_q <= col_q + ColW'(1);
							end
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (polar_start) begin
			rend_q <= row_end;
			fend_q <= frame_end;
		end
		case (state_q)
			ST_MUL: begin
				mag_q <= polar.mag;
				p_q <= 21'(ang) * 21'(bins_used);
			end
			ST_SPLIT: begin
				// p / span, p mod span
				if (full_q) begin
					lo_q <= (p_q[20:16] >= 5'(bins_used)) ? BinW'(bins_used - 1)
						: p_q[16+BinW-1:16];
					prod_q <= 36'(mag_q) * 36'(p_q[15:0]);
				end else begin
					lo_q <= (p_q[20:15] >= 6'(bins_used)) ? BinW'(bins_used - 1)
						: p_q[15+BinW-1:15];
					prod_q <= 36'(mag_q) * 36'(p_q[14:0]);
				end
				add_hi_q <= 1'b0;
				n_q <= '0;
			end
			ST_ADD: begin
				if (!add_hi_q) begin
					add_hi_q <= 1'b1;
				end
			end
			ST_READ: above_q <= line_mem[addr];
			ST_EMIT: begin
				if (!out_valid) begin
					bin_index <= 4'(n_q);
					bin_sum <= osum[BinSumW] ? BinSumMax : osum[BinSumW-1:0];
					pixel_done <= (BinCntW'(n_q) + BinCntW'(1) == bins_used);
					line_mem[addr] <= osum[BinSumW] ? BinSumMax : osum[BinSumW-1:0];
				end else if (out_ready) begin
					n_q <= n_q + BinW'(1);
				end
			end
			default: ;
		endcase
	end

	// upper share and wrapping upper bin
	always_comb begin
		up_q = full_q ? prod_q[MagW+15:16] : prod_q[MagW+14:15];
		hi_q = (BinCntW'(lo_q) + BinCntW'(1) >= bins_used) ? '0 : lo_q + BinW'(1);
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !ready)
		else $error("output item while accepting");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_sum))
		else $error("stalled item lost");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (5'(bin_index) < bins_used))
		else $error("bin out of range");
endmodule

// ===== tb/tb_integral_orientation_histogram.sv =====
`timescale 1ns / 100ps

module tb_integral_orientation_histogram;
	import ioh_pkg::*;

	typedef struct {
		logic [3:0] bin;
		logic [47:0] sum;
		logic done;
	} bin_result_t;

	localparam int IdleLimit = 20000;
	localparam int DrainWait = 80;
	localparam int HoldCycles = 400;

	// arctan steps in 2^-16 turn units
	localparam int TurnStep [0:13] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
		10, 5, 3, 1};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic valid = 1'b0;
	logic ready;
	logic signed [10:0] grad_x = '0;
	logic signed [10:0] grad_y = '0;
	logic row_end = 1'b0;
	logic frame_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [3:0] bin_index;
	logic [47:0] bin_sum;
	logic pixel_done;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// shadow of the block's state
	int unsigned cfg_bins = 8;
	bit cfg_full = 1'b0;
	logic [39:0] row_sums [MaxBins];
	logic [47:0] line_mem [MaxWidth*MaxBins];
	int unsigned col_pos = 0;
	bit top_row = 1'b1;

	bin_result_t expected_bins[$];
	int errors = 0;
	int pixels_sent = 0;
	int bins_checked = 0;
	int idle_cycles = 0;
	bit steady_flow = 1'b0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	integral_orientation_histogram DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic int unsigned gradient_angle(input int gx, input int gy);
		longint x, y, xs, ys;
		int z;
		x = longint'(gx) * 256;
		y = longint'(gy) * 256;
		z = 0;
		if (gx == 0 && gy == 0) return 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32768;
		end
		for (int i = 0; i < CordicSteps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x += ys;
				y -= xs;
				z += TurnStep[i];
			end else begin
				x -= ys;
				y += xs;
				z -= TurnStep[i];
			end
		end
		return z & 32'hFFFF;
	endfunction

	function automatic void add_row_share(input int unsigned b, input longint unsigned v);
		longint unsigned s;
		s = row_sums[b] + v;
		row_sums[b] = (s > RowSumMax) ? RowSumMax : s[39:0];
	endfunction

	// expected bin sums of one pixel, updates the shadow state
	function automatic void histogram_pixel(input int gx, input int gy, input bit re,
			input bit fe);
		int unsigned nbins, span, angle, lo, hi, idx;
		longint unsigned mag, p, frac, up, s, above;
		bin_result_t r;
		nbins = (cfg_bins == 0) ? 1 : (cfg_bins > MaxBins ? MaxBins : cfg_bins);
		mag = int_sqrt(longint'(gx * gx + gy * gy) << 16);
		angle = gradient_angle(gx, gy);
		if (cfg_full) begin
			span = 65536;
		end else begin
			span = 32768;
			if (angle >= span) angle -= span;
		end
		p = longint'(angle) * nbins;
		lo = 32'(p / span);
		frac = p % span;
		if (lo >= nbins) lo = nbins - 1;
		hi = (lo + 1) % nbins;
		up = (mag * frac) / span;
		add_row_share(lo, mag - up);
		add_row_share(hi, up);
		for (int n = 0; n < nbins; n++) begin
			idx = (col_pos % MaxWidth) * MaxBins + n;
			above = top_row ? 0 : line_mem[idx];
			s = row_sums[n] + above;
			if (s > BinSumMax) s = BinSumMax;
			line_mem[idx] = s[47:0];
			r.bin = n[3:0];
			r.sum = s[47:0];
			r.done = (n + 1 == nbins);
			expected_bins = {expected_bins, r};
		end
		if (fe || re) begin
			foreach (row_sums[i]) row_sums[i] = '0;
			col_pos = 0;
			top_row = fe;
		end else begin
			col_pos = (col_pos + 1) % MaxWidth;
		end
	endfunction

	// send one pixel, with a random gap before it unless the flow is steady
	task automatic send_pixel(input int gx, input int gy, input bit re, input bit fe);
		@(negedge clk);
		while (!steady_flow && $urandom_range(99) < 35) begin
			valid <= 1'b0;
			@(negedge clk);
		end
		valid <= 1'b1;
		grad_x <= gx[10:0];
		grad_y <= gy[10:0];
		row_end <= re;
		frame_end <= fe;
		do @(posedge clk); while (!ready);
		histogram_pixel(gx, gy, re, fe);
		pixels_sent++;
		@(negedge clk);
		valid <= 1'b0;
	endtask

	task automatic wait_drained();
		wait (expected_bins.size() == 0);
		repeat (DrainWait) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] reg_idx, input int unsigned value);
		wait_drained();
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 3'(reg_idx) << 2;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (reg_idx == REG_BIN_COUNT) cfg_bins = value & 5'h1F;
		else if (reg_idx == REG_FULL_ORIENT) cfg_full = value[0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_mode(input int unsigned count, input bit full);
		write_reg(REG_BIN_COUNT, count);
		write_reg(REG_FULL_ORIENT, full);
	endtask

	function automatic int rand_grad();
		case ($urandom_range(5))
			0: return -1024;
			1: return 1023;
			2: return $urandom_range(20) - 10;
			default: return int'($urandom_range(2047)) - 1024;
		endcase
	endfunction

	// a frame of rows; later rows never outgrow the first
	task automatic send_frame(input int rows, input int width);
		int w;
		for (int r = 0; r < rows; r++) begin
			w = (r == 0) ? width : $urandom_range(width, 1);
			for (int c = 0; c < w; c++) begin
				send_pixel(rand_grad(), rand_grad(), c == w - 1 && (r < rows - 1 ||
					$urandom_range(1)), r == rows - 1 && c == w - 1);
			end
		end
	endtask

	task automatic test_directed();
		set_mode(8, 1'b0);
		send_pixel(0, 0, 1'b0, 1'b0);
		send_pixel(-1024, -1024, 1'b0, 1'b0);
		send_pixel(1023, 1023, 1'b0, 1'b0);
		send_pixel(-1024, 0, 1'b0, 1'b0);
		send_pixel(0, 1023, 1'b1, 1'b0);
		send_pixel(1023, -1024, 1'b0, 1'b0);
		send_pixel(0, -1024, 1'b0, 1'b0);
		send_pixel(-1, 1, 1'b1, 1'b0);
		send_pixel(1023, 0, 1'b0, 1'b0);
		// frame end on its own, without row end
		send_pixel(-1024, 1023, 1'b0, 1'b1);
		set_mode(16, 1'b1);
		send_pixel(-1024, -1, 1'b1, 1'b0);
		send_pixel(1, -1024, 1'b1, 1'b1);
	endtask

	task automatic test_bin_count_limits();
		// zero bins folds to one, counts past the maximum clamp
		set_mode(0, 1'b1);
		send_frame(2, 3);
		set_mode(31, 1'b0);
		send_frame(2, 2);
		set_mode(1, 1'b0);
		send_frame(2, 2);
		set_mode(17, 1'b1);
		send_frame(1, 2);
	endtask

	task automatic test_backpressure();
		set_mode(16, 1'b0);
		hold_requests++;
		send_frame(2, 4);
		wait_drained();
	endtask

	task automatic test_random_frames();
		int target;
		// one frame with no idling on either side
		set_mode(8, 1'b1);
		steady_flow = 1'b1;
		send_frame(3, 8);
		steady_flow = 1'b0;
		target = pixels_sent + 90;
		while (pixels_sent < target) begin
			set_mode($urandom_range(31), $urandom_range(1));
			steady_flow = ($urandom_range(4) == 0);
			send_frame($urandom_range(4, 1), $urandom_range(8, 1));
		end
		steady_flow = 1'b0;
	endtask

	// receiver: random stalls, long hold-offs on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HoldCycles;
			out_ready <= 1'b0;
		end else begin
			out_ready <= steady_flow || ($urandom_range(99) >= 35);
		end
	end

	// compare each bin item with the oldest expected one
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			bins_checked++;
			if (expected_bins.size() == 0) begin
				errors++;
				$display("%0t: unexpected item bin %0d sum %0h done %0b", $time, bin_index,
					bin_sum, pixel_done);
			end else begin
				if (bin_index !== expected_bins[0].bin) begin
					errors++;
					$display("%0t: bin_index expected %0d actual %0d", $time,
						expected_bins[0].bin, bin_index);
				end
				if (bin_sum !== expected_bins[0].sum) begin
					errors++;
					$display("%0t: bin_sum expected %0h actual %0h", $time,
						expected_bins[0].sum, bin_sum);
				end
				if (pixel_done !== expected_bins[0].done) begin
					errors++;
					$display("%0t: pixel_done expected %0b actual %0b", $time,
						expected_bins[0].done, pixel_done);
				end
				void'(expected_bins.pop_front());
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((valid && ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("%0t: timeout, %0d bin items outstanding", $time, expected_bins.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		foreach (row_sums[i]) row_sums[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_bin_count_limits();
		test_backpressure();
		test_random_frames();
		wait_drained();
		$display("covered %0d pixels and %0d bin items over bin counts 0..31,", pixels_sent,
			bins_checked);
		$display("both orientation spans, gradient extremes and long output stalls");
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
